@@ src/fms_pkg.sv @@
package fms_pkg;

  // item actions
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_WORD    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] ST_REG_SUM   = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_EMPTY_REG = 2'd3;

  // structure block tokens
  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  // parse phases
  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_NAME     = 3'd1;
  localparam logic [2:0] PH_PROP_LEN = 3'd2;
  localparam logic [2:0] PH_PROP_OFF = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;
  localparam logic [2:0] PH_REG      = 3'd5;

  // name characters that are matched
  localparam logic [7:0] CH_M = 8'h6d;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_Y = 8'h79;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_G = 8'h67;

  // one reg entry: two address cells and two size cells
  localparam int ENTRY_BYTES = 16;

  // registered item handed to the parser
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] word;
    logic [7:0]  str_lo;
    logic [7:0]  str_hi;
  } fms_item_t;

  // parser decision for the current item
  typedef struct packed {
    logic        emit;
    logic [1:0]  status;
    logic [63:0] total;
  } fms_result_t;

endpackage

@@ src/fms_ram.sv @@
module fms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ src/fms_parser.sv @@
module fms_parser
  import fms_pkg::*;
#(
  parameter int STRING_STORE_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  fms_item_t   item,
  output fms_result_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic        in_mem_r, in_mem_nxt;
  logic [1:0]  name_idx_r, name_idx_nxt;
  logic [15:0] name_first_r, name_first_nxt;
  logic [30:0] skip_r, skip_nxt;
  logic [27:0] entries_r, entries_nxt;
  logic [1:0]  entry_idx_r, entry_idx_nxt;
  logic [31:0] high_hold_r, high_hold_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [31:0] prop_len_r, prop_len_nxt;
  logic        finished_r, finished_nxt;

  logic [31:0] w;
  logic        zero_byte;
  logic        off_in_range;
  logic        is_reg;
  logic [30:0] skip_calc;
  logic [27:0] entries_dec;
  logic [63:0] sum_add;

  assign w = item.word;
  assign zero_byte = (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
                     (w[15:8] == 8'd0) || (w[7:0] == 8'd0);
  assign off_in_range = ({1'b0, w} + 33'd2) < 33'(STRING_STORE_BYTES);
  assign is_reg = off_in_range && (item.str_lo == CH_R) && (item.str_hi == CH_G);
  assign skip_calc = {1'b0, prop_len_r[31:2]} + {30'd0, |prop_len_r[1:0]};
  assign entries_dec = (entries_r != 28'd0) ? entries_r - 28'd1 : entries_r;
  assign sum_add = sum_r + {high_hold_r, w};

  // next parse state for the current item
  always_comb begin
    phase_nxt      = phase_r;
    in_mem_nxt     = in_mem_r;
    name_idx_nxt   = name_idx_r;
    name_first_nxt = name_first_r;
    skip_nxt       = skip_r;
    entries_nxt    = entries_r;
    entry_idx_nxt  = entry_idx_r;
    high_hold_nxt  = high_hold_r;
    sum_nxt        = sum_r;
    prop_len_nxt   = prop_len_r;
    finished_nxt   = finished_r;
    res.emit       = 1'b0;
    res.status     = ST_REG_SUM;
    res.total      = 64'd0;

    if (item.action == ACT_RESTART) begin
      phase_nxt      = PH_TOKEN;
      in_mem_nxt     = 1'b0;
      name_idx_nxt   = 2'd0;
      name_first_nxt = 16'd0;
      skip_nxt       = 31'd0;
      entries_nxt    = 28'd0;
      entry_idx_nxt  = 2'd0;
      high_hold_nxt  = 32'd0;
      sum_nxt        = 64'd0;
      prop_len_nxt   = 32'd0;
      finished_nxt   = 1'b0;
    end else if (item.action == ACT_WORD && !finished_r) begin
      case (phase_r)
        PH_TOKEN: begin
          if (w == TOK_BEGIN_NODE) begin
            in_mem_nxt     = 1'b0;
            name_idx_nxt   = 2'd0;
            name_first_nxt = 16'd0;
            phase_nxt      = PH_NAME;
          end else if (w == TOK_PROP) begin
            phase_nxt = PH_PROP_LEN;
          end else if (w == TOK_END_NODE) begin
            in_mem_nxt = 1'b0;
          end else if (w == TOK_NOP) begin
            phase_nxt = PH_TOKEN;
          end else if (w == TOK_END) begin
            res.emit   = 1'b1;
            res.status = ST_END;
          end else begin
            res.emit   = 1'b1;
            res.status = ST_UNKNOWN;
          end
        end
        PH_NAME: begin
          if (name_idx_r == 2'd0) begin
            name_first_nxt = w[31:16];
          end else if (name_idx_r == 2'd1) begin
            if (name_first_r == {CH_M, CH_E} && w[23:16] == CH_Y) begin
              in_mem_nxt = 1'b1;
            end
          end
          if (name_idx_r != 2'd2) begin
            name_idx_nxt = name_idx_r + 2'd1;
          end
          if (zero_byte) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_PROP_LEN: begin
          prop_len_nxt = w;
          phase_nxt    = PH_PROP_OFF;
        end
        PH_PROP_OFF: begin
          if (in_mem_r && is_reg) begin
            entries_nxt = prop_len_r[31:4];
            if (prop_len_r == 32'd0) begin
              res.emit   = 1'b1;
              res.status = ST_EMPTY_REG;
            end else if (prop_len_r[31:4] == 28'd0) begin
              res.emit   = 1'b1;
              res.status = ST_REG_SUM;
            end else begin
              entry_idx_nxt = 2'd0;
              sum_nxt       = 64'd0;
              phase_nxt     = PH_REG;
            end
          end else begin
            skip_nxt  = skip_calc;
            phase_nxt = (skip_calc != 31'd0) ? PH_SKIP : PH_TOKEN;
          end
        end
        PH_SKIP: begin
          if (skip_r != 31'd0) begin
            skip_nxt = skip_r - 31'd1;
          end
          if (skip_r == 31'd0 || skip_r == 31'd1) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_REG: begin
          entry_idx_nxt = entry_idx_r + 2'd1;
          if (entry_idx_r == 2'd2) begin
            high_hold_nxt = w;
          end else if (entry_idx_r == 2'd3) begin
            sum_nxt     = sum_add;
            entries_nxt = entries_dec;
            if (entries_dec == 28'd0) begin
              entry_idx_nxt = 2'd0;
              res.emit      = 1'b1;
              res.status    = ST_REG_SUM;
              res.total     = sum_add;
            end
          end
        end
        default: begin
          phase_nxt = PH_TOKEN;
        end
      endcase
      // a result ends the scan until restart
      if (res.emit) begin
        finished_nxt = 1'b1;
        phase_nxt    = PH_TOKEN;
      end
    end
  end

  // parse state advances when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TOKEN;
      in_mem_r     <= 1'b0;
      name_idx_r   <= 2'd0;
      name_first_r <= 16'd0;
      skip_r       <= 31'd0;
      entries_r    <= 28'd0;
      entry_idx_r  <= 2'd0;
      high_hold_r  <= 32'd0;
      sum_r        <= 64'd0;
      prop_len_r   <= 32'd0;
      finished_r   <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      in_mem_r     <= in_mem_nxt;
      name_idx_r   <= name_idx_nxt;
      name_first_r <= name_first_nxt;
      skip_r       <= skip_nxt;
      entries_r    <= entries_nxt;
      entry_idx_r  <= entry_idx_nxt;
      high_hold_r  <= high_hold_nxt;
      sum_r        <= sum_nxt;
      prop_len_r   <= prop_len_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule

@@ src/fdt_memory_size_scanner.sv @@
// Device tree memory size scanner.
// Input channel (in_valid/in_ready) takes one item per cycle: a strings
// block byte load, a big-endian structure block word, or a parse restart.
// Load the strings block first, then stream the structure block words.
// Result channel (out_valid/out_ready) delivers at most one result per
// scan: the summed reg sizes of the first memory node, or a status for an
// end token, an unknown token or an empty reg. After a result, words are
// ignored until a restart item.
// An accepted item passes the input stage, where the strings store read
// completes, and then its result lands in the result register.
// The single input stage keeps one item per cycle unless a stalled result
// holds it; the store write and reads share no port.
// Reset clears the parse state and both stages; the strings store keeps
// no reset value and must be loaded before it is used.
// When the receiver stalls, a waiting result holds while the input stage
// still takes items that produce no result; an item that would produce a
// result waits in the input stage and then in_ready drops.
module fdt_memory_size_scanner
  import fms_pkg::*;
#(
  parameter int STRING_STORE_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_struct_word,
  input  logic [9:0]  in_string_address,
  input  logic [7:0]  in_string_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_total_ram
);

  localparam int AW = $clog2(STRING_STORE_BYTES);

  logic        in_accept;
  logic        s1_valid_r;
  logic [1:0]  s1_action_r;
  logic [31:0] s1_word_r;
  logic        s1_go;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [63:0] out_total_r;

  logic          ram_we;
  logic [31:0]   waddr_ext;
  logic [31:0]   raddr_hi_ext;
  logic [7:0]    str_lo;
  logic [7:0]    str_hi;
  fms_item_t     item;
  fms_result_t   res;

  assign in_accept = in_valid && in_ready;
  assign s1_go     = s1_valid_r && (!res.emit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;

  // strings store: written at load acceptance, read at word acceptance
  assign waddr_ext    = {22'd0, in_string_address};
  assign raddr_hi_ext = in_struct_word + 32'd2;
  assign ram_we = in_accept && (in_action == ACT_LOAD) &&
                  (waddr_ext < 32'(STRING_STORE_BYTES));

  fms_ram #(
    .WIDTH(8),
    .DEPTH(STRING_STORE_BYTES)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr_ext[AW-1:0]),
    .wdata  (in_string_byte),
    .re     (in_accept && (in_action == ACT_WORD)),
    .raddr_a(in_struct_word[AW-1:0]),
    .raddr_b(raddr_hi_ext[AW-1:0]),
    .rdata_a(str_lo),
    .rdata_b(str_hi)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_word_r   <= in_struct_word;
    end
  end

  assign item.action = s1_action_r;
  assign item.word   = s1_word_r;
  assign item.str_lo = str_lo;
  assign item.str_hi = str_hi;

  fms_parser #(
    .STRING_STORE_BYTES(STRING_STORE_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (s1_go),
    .item (item),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_status_r <= res.status;
      out_total_r  <= res.total;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_total_ram = out_total_r;

  // an empty input stage always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  // a result leaving the input stage lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res.emit) |=> (out_valid_r && out_status_r == $past(res.status)))
    else $error("result lost on its way to the output");

  // a stalled input stage keeps its item
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_word_r) &&
                                $stable(s1_action_r)))
    else $error("stalled input stage item changed");

  // only a reg sum carries a nonzero total
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_REG_SUM) |-> (out_total_r == 64'd0))
    else $error("nonzero total with a non-sum status");

endmodule
